FILE: hdl/vpd_pkg.sv
// Shared types and constants for the vocoder packet deframer.
// Used by vpd_parser and vocoder_packet_deframer; depends on nothing.
package vpd_pkg;

  // Most results one received word can cause (template prefix plus three words)
  localparam int unsigned NRES = 6;

  // Fixed header bytes
  localparam logic [7:0] START_BYTE   = 8'h61;
  localparam logic [7:0] TYPE_AUDIO   = 8'h02;
  localparam logic [7:0] TYPE_CODED   = 8'h01;
  localparam logic [7:0] TYPE_CTRL    = 8'h00;
  localparam logic [7:0] CTRL_PRODUCT = 8'h30;
  localparam logic [7:0] CTRL_RATE    = 8'h0A;

  // Length field counts the packet minus its four header bytes
  localparam logic [12:0] HDR_EXTRA = 13'd4;

  // Header templates, element 0 is the start byte
  localparam logic [NRES-1:0][7:0] TPL_AUDIO =
    {8'hA0, 8'h00, 8'h02, 8'h42, 8'h01, 8'h61};
  localparam logic [NRES-1:0][7:0] TPL_CODED =
    {8'h48, 8'h01, 8'h01, 8'h0B, 8'h00, 8'h61};

  // Packet kinds reported on the last result
  localparam logic [2:0] KIND_PENDING = 3'd0;
  localparam logic [2:0] KIND_AUDIO   = 3'd1;
  localparam logic [2:0] KIND_CODED   = 3'd2;
  localparam logic [2:0] KIND_PRODUCT = 3'd3;
  localparam logic [2:0] KIND_RATE    = 3'd4;
  localparam logic [2:0] KIND_UNKNOWN = 3'd5;

  // Deframer phase, one-hot
  typedef enum logic [5:0] {
    PH_IDLE  = 6'b000001,
    PH_HOLD1 = 6'b000010,
    PH_HOLD2 = 6'b000100,
    PH_LENHI = 6'b001000,
    PH_LENLO = 6'b010000,
    PH_BODY  = 6'b100000
  } vpd_phase_t;

  // One result word
  typedef struct packed {
    logic [7:0]  data;
    logic [12:0] idx;
    logic        vld;
    logic        last;
    logic [2:0]  kind;
    logic        realign;
  } vpd_res_t;

  // All results of one received word
  typedef struct packed {
    vpd_res_t [NRES-1:0] ent;
    logic [2:0]          n;
  } vpd_burst_t;

endpackage

FILE: hdl/vpd_parser.sv
// Packet parser: holds the framing state and turns one received word into
// its burst of result words. Depends on vpd_pkg.
module vpd_parser import vpd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  logic [7:0] rx_byte,
  output vpd_burst_t burst
);

  vpd_phase_t  phase_r, phase_nxt;
  logic [7:0]  held0_r, held0_nxt;
  logic [7:0]  held1_r, held1_nxt;
  logic [7:0]  ftype_r, ftype_nxt;
  logic [7:0]  ctrl_r, ctrl_nxt;
  logic [12:0] flen_r, flen_nxt;
  logic [12:0] bcnt_r, bcnt_nxt;
  logic        realign_r, realign_nxt;

  logic [2:0][7:0]      got;
  logic [NRES-1:0][7:0] pkt;
  logic                 found;
  logic                 use_coded;
  logic [1:0]           off;
  logic [2:0]           pos;
  logic [7:0]           body_type;
  logic [7:0]           body_ctrl;
  logic                 body_end;

  function automatic logic [2:0] classify(input logic [7:0] ft, input logic [7:0] cc);
    logic [2:0] k;
    k = KIND_UNKNOWN;
    if (ft == TYPE_AUDIO) k = KIND_AUDIO;
    else if (ft == TYPE_CODED) k = KIND_CODED;
    else if (ft == TYPE_CTRL) begin
      if (cc == CTRL_PRODUCT) k = KIND_PRODUCT;
      else if (cc == CTRL_RATE) k = KIND_RATE;
    end
    return k;
  endfunction

  // Match the three opening words against the templates, first hit wins
  always_comb begin
    got       = {rx_byte, held1_r, held0_r};
    found     = 1'b0;
    use_coded = 1'b0;
    off       = 2'd1;
    for (int o = 1; o < 4; o++) begin
      if (!found) begin
        if (TPL_AUDIO[o] == got[0] && TPL_AUDIO[o+1] == got[1] &&
            TPL_AUDIO[o+2] == got[2]) begin
          found = 1'b1;
          off   = 2'(o);
        end else if (TPL_CODED[o] == got[0] && TPL_CODED[o+1] == got[1] &&
                     TPL_CODED[o+2] == got[2]) begin
          found     = 1'b1;
          use_coded = 1'b1;
          off       = 2'(o);
        end
      end
    end
    // Supply the missing prefix, then place the received words after it
    pkt = use_coded ? TPL_CODED : TPL_AUDIO;
    pos = 3'd0;
    for (int k = 0; k < 3; k++) begin
      pos      = {1'b0, off} + 3'(k);
      pkt[pos] = got[k];
    end
  end

  // Body word: capture type and control, detect the packet end
  always_comb begin
    body_type = (bcnt_r == 13'd3) ? rx_byte : ftype_r;
    body_ctrl = (bcnt_r == 13'd4) ? rx_byte : ctrl_r;
    body_end  = ({1'b0, bcnt_r} + 14'd1) >= {1'b0, flen_r};
  end

  // Next state and result words
  always_comb begin
    phase_nxt   = phase_r;
    held0_nxt   = held0_r;
    held1_nxt   = held1_r;
    ftype_nxt   = ftype_r;
    ctrl_nxt    = ctrl_r;
    flen_nxt    = flen_r;
    bcnt_nxt    = bcnt_r;
    realign_nxt = realign_r;
    burst       = '0;

    unique case (phase_r)
      PH_HOLD1: begin
        held1_nxt = rx_byte;
        phase_nxt = PH_HOLD2;
      end
      PH_HOLD2: begin
        if (!found) begin
          // Drop the three words and give a drop notice
          phase_nxt               = PH_IDLE;
          burst.ent[0].last       = 1'b1;
          burst.ent[0].kind       = KIND_UNKNOWN;
          burst.n                 = 3'd1;
        end else begin
          realign_nxt = 1'b1;
          flen_nxt    = {1'b0, pkt[1][3:0], pkt[2]} + HDR_EXTRA;
          ftype_nxt   = pkt[3];
          ctrl_nxt    = (off != 2'd1) ? pkt[4] : 8'h00;
          for (int i = 0; i < NRES; i++) begin
            burst.ent[i].data    = pkt[i];
            burst.ent[i].idx     = 13'(i);
            burst.ent[i].vld     = 1'b1;
            burst.ent[i].realign = 1'b1;
          end
          burst.n   = {1'b0, off} + 3'd3;
          bcnt_nxt  = {10'd0, burst.n};
          phase_nxt = PH_BODY;
        end
      end
      PH_LENHI: begin
        held0_nxt             = rx_byte;
        burst.ent[0].data     = rx_byte;
        burst.ent[0].idx      = 13'd1;
        burst.ent[0].vld      = 1'b1;
        burst.ent[0].realign  = realign_r;
        burst.n               = 3'd1;
        bcnt_nxt              = 13'd2;
        phase_nxt             = PH_LENLO;
      end
      PH_LENLO: begin
        flen_nxt              = {1'b0, held0_r[3:0], rx_byte} + HDR_EXTRA;
        burst.ent[0].data     = rx_byte;
        burst.ent[0].idx      = 13'd2;
        burst.ent[0].vld      = 1'b1;
        burst.ent[0].realign  = realign_r;
        burst.n               = 3'd1;
        bcnt_nxt              = 13'd3;
        phase_nxt             = PH_BODY;
      end
      PH_BODY: begin
        ftype_nxt             = body_type;
        ctrl_nxt              = body_ctrl;
        burst.ent[0].data     = rx_byte;
        burst.ent[0].idx      = bcnt_r;
        burst.ent[0].vld      = 1'b1;
        burst.ent[0].last     = body_end;
        burst.ent[0].kind     = body_end ? classify(body_type, body_ctrl) : KIND_PENDING;
        burst.ent[0].realign  = realign_r;
        burst.n               = 3'd1;
        if (body_end) phase_nxt = PH_IDLE;
        else bcnt_nxt = bcnt_r + 13'd1;
      end
      default: begin
        // Idle, and any code that is not a phase
        if (rx_byte == START_BYTE) begin
          ftype_nxt         = 8'h00;
          ctrl_nxt          = 8'h00;
          flen_nxt          = 13'd0;
          realign_nxt       = 1'b0;
          burst.ent[0].data = rx_byte;
          burst.ent[0].vld  = 1'b1;
          burst.n           = 3'd1;
          bcnt_nxt          = 13'd1;
          phase_nxt         = PH_LENHI;
        end else begin
          held0_nxt = rx_byte;
          phase_nxt = PH_HOLD1;
        end
      end
    endcase
  end

  // Advance the framing state on each accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      held0_r   <= '0;
      held1_r   <= '0;
      ftype_r   <= '0;
      ctrl_r    <= '0;
      flen_r    <= '0;
      bcnt_r    <= '0;
      realign_r <= 1'b0;
    end else if (take) begin
      phase_r   <= phase_nxt;
      held0_r   <= held0_nxt;
      held1_r   <= held1_nxt;
      ftype_r   <= ftype_nxt;
      ctrl_r    <= ctrl_nxt;
      flen_r    <= flen_nxt;
      bcnt_r    <= bcnt_nxt;
      realign_r <= realign_nxt;
    end
  end

endmodule

FILE: hdl/vocoder_packet_deframer.sv
// Vocoder packet deframer: first result appears in the cycle after a word is accepted.
// Throughput one word per cycle while out_ready is high; a realigned header gives up to six results,
// drained one per cycle from the result buffer while input waits and out_ready is high.
// Input is taken while the last buffered result leaves, so results flow back to back.
// Reset (rst_n low, synchronous) returns to idle and empties the result buffer.
// Depends on vpd_pkg and vpd_parser.
module vocoder_packet_deframer import vpd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic [12:0] out_byte_index,
  output logic        out_byte_valid,
  output logic        out_packet_end,
  output logic [2:0]  out_packet_kind,
  output logic        out_realigned
);

  vpd_burst_t          burst;
  vpd_res_t [NRES-1:0] ent_r;
  logic [2:0]          rd_r;
  logic [2:0]          cnt_r;
  logic                take;
  logic                pop;
  vpd_res_t            head;

  // Accept a word when the buffer is empty or its last result leaves now
  assign out_valid = (cnt_r != 3'd0);
  assign pop       = out_valid & out_ready;
  assign in_ready  = (cnt_r == 3'd0) || (cnt_r == 3'd1 && out_ready);
  assign take      = in_valid & in_ready;

  vpd_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .rx_byte (in_rx_byte),
    .burst   (burst)
  );

  // Load a new burst or drain one result per cycle while out_ready is high
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r  <= '0;
      cnt_r <= '0;
    end else if (take) begin
      rd_r  <= '0;
      cnt_r <= burst.n;
    end else if (pop) begin
      rd_r  <= rd_r + 3'd1;
      cnt_r <= cnt_r - 3'd1;
    end
  end

  // Hold the result words of the burst
  always_ff @(posedge clk) begin
    if (take) ent_r <= burst.ent;
  end

  assign head            = ent_r[rd_r];
  assign out_byte        = head.data;
  assign out_byte_index  = head.idx;
  assign out_byte_valid  = head.vld;
  assign out_packet_end  = head.last;
  assign out_packet_kind = head.kind;
  assign out_realigned   = head.realign;

endmodule

FILE: bench/vocoder_packet_deframer_tb.sv
// Self-checking bench for vocoder_packet_deframer: a random-paced word driver and
// result monitor, checked against an in-bench deframer model.
// Depends on vpd_pkg and the vocoder_packet_deframer RTL.
module vocoder_packet_deframer_tb;
  import vpd_pkg::*;

  localparam logic [7:0] CTRL_READY = 8'h39;
  localparam int         MAX_WAIT   = 18;
  localparam int         N_WORDS    = 420;

  typedef struct packed {
    logic [7:0] b;
    logic       hold;
  } rx_word_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic [12:0] out_byte_index;
  logic        out_byte_valid;
  logic        out_packet_end;
  logic [2:0]  out_packet_kind;
  logic        out_realigned;

  vocoder_packet_deframer i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_byte_index (out_byte_index),
    .out_byte_valid (out_byte_valid),
    .out_packet_end (out_packet_end),
    .out_packet_kind(out_packet_kind),
    .out_realigned  (out_realigned)
  );

  rx_word_t rx_q[$];        // words still to send
  vpd_res_t deframed_q[$];  // deframed words still owed by the block
  bit       pause_next;
  int       n_words_in, n_results, n_drops, n_realigned, n_errors;
  int       kind_seen [0:7];

  // Deframer model state
  vpd_phase_t  dp_phase;
  logic [7:0]  dp_held [2];
  logic [7:0]  dp_type, dp_ctrl;
  logic [12:0] dp_len, dp_cnt;
  logic        dp_realign;

  // Pacing state of both sides
  int snd_wait, rcv_wait, rcv_draw;
  bit snd_fast, rcv_fast;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void push_res(logic [7:0] d, logic [12:0] idx, logic vld, logic last,
                                   logic [2:0] kind, logic re);
    vpd_res_t r;
    r.data    = d;
    r.idx     = idx;
    r.vld     = vld;
    r.last    = last;
    r.kind    = kind;
    r.realign = re;
    deframed_q.push_back(r);
  endfunction

  // Advance the deframer model by one accepted word and queue what it emits
  function automatic void deframe_word(logic [7:0] b);
    logic [7:0]           got [3];
    logic [7:0]           hdr [6];
    logic [NRES-1:0][7:0] tpl, cand;
    int                   off, n;
    logic                 last;
    logic [2:0]           kind;
    case (dp_phase)
      PH_IDLE: begin
        if (b == START_BYTE) begin
          dp_type    = '0;
          dp_ctrl    = '0;
          dp_len     = '0;
          dp_realign = 1'b0;
          push_res(b, 13'd0, 1'b1, 1'b0, KIND_PENDING, 1'b0);
          dp_cnt   = 13'd1;
          dp_phase = PH_LENHI;
        end else begin
          dp_held[0] = b;
          dp_phase   = PH_HOLD1;
        end
      end
      PH_HOLD1: begin
        dp_held[1] = b;
        dp_phase   = PH_HOLD2;
      end
      PH_HOLD2: begin
        got[0] = dp_held[0];
        got[1] = dp_held[1];
        got[2] = b;
        off    = 0;
        // Try offsets in order, audio ahead of coded voice; first hit wins
        for (int i = 1; i < 4 && off == 0; i++) begin
          for (int t = 0; t < 2 && off == 0; t++) begin
            cand = (t == 0) ? TPL_AUDIO : TPL_CODED;
            if (cand[i] == got[0] && cand[i+1] == got[1] && cand[i+2] == got[2]) begin
              tpl = cand;
              off = i;
            end
          end
        end
        if (off == 0) begin
          dp_phase = PH_IDLE;
          push_res(8'h00, 13'd0, 1'b0, 1'b1, KIND_UNKNOWN, 1'b0);
        end else begin
          // Rebuild the header: template prefix, then the three held words
          n = off + 3;
          for (int i = 0; i < off; i++) hdr[i] = tpl[i];
          for (int i = 0; i < 3; i++) hdr[off+i] = got[i];
          dp_realign = 1'b1;
          dp_len     = {hdr[1][3:0], hdr[2]} + HDR_EXTRA;
          dp_type    = hdr[3];
          dp_ctrl    = (n > 4) ? hdr[4] : 8'h00;
          for (int i = 0; i < n; i++)
            push_res(hdr[i], 13'(i), 1'b1, 1'b0, KIND_PENDING, 1'b1);
          dp_cnt   = 13'(n);
          dp_phase = PH_BODY;
        end
      end
      PH_LENHI: begin
        dp_held[0] = b;
        push_res(b, 13'd1, 1'b1, 1'b0, KIND_PENDING, dp_realign);
        dp_cnt   = 13'd2;
        dp_phase = PH_LENLO;
      end
      PH_LENLO: begin
        dp_len = {dp_held[0][3:0], b} + HDR_EXTRA;
        push_res(b, 13'd2, 1'b1, 1'b0, KIND_PENDING, dp_realign);
        dp_cnt   = 13'd3;
        dp_phase = PH_BODY;
      end
      default: begin
        // Body: capture type and control, classify on the last word
        if (dp_cnt == 13'd3) dp_type = b;
        if (dp_cnt == 13'd4) dp_ctrl = b;
        last = (dp_cnt + 13'd1 >= dp_len);
        kind = KIND_PENDING;
        if (last) begin
          if (dp_type == TYPE_AUDIO) kind = KIND_AUDIO;
          else if (dp_type == TYPE_CODED) kind = KIND_CODED;
          else if (dp_type == TYPE_CTRL && dp_ctrl == CTRL_PRODUCT) kind = KIND_PRODUCT;
          else if (dp_type == TYPE_CTRL && dp_ctrl == CTRL_RATE) kind = KIND_RATE;
          else kind = KIND_UNKNOWN;
        end
        push_res(b, dp_cnt, 1'b1, last, kind, dp_realign);
        if (last) dp_phase = PH_IDLE;
        else dp_cnt = dp_cnt + 13'd1;
      end
    endcase
  endfunction

  function automatic void check_field(string name, logic [12:0] want, logic [12:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_errors++;
    end
  endfunction

  // Stimulus builders
  function automatic void put_word(logic [7:0] b);
    rx_word_t w;
    w.b        = b;
    w.hold     = pause_next;
    pause_next = 1'b0;
    rx_q.push_back(w);
  endfunction

  // Random body content; keep start bytes out so packet boundaries stay known
  function automatic logic [7:0] filler();
    logic [7:0] v;
    v = 8'($urandom);
    if (v == START_BYTE) v = 8'h60;
    return v;
  endfunction

  function automatic void put_packet(logic [7:0] len_hi, logic [7:0] len_lo,
                                     logic [7:0] ptype, logic [7:0] ctrl);
    int total;
    total = int'({len_hi[3:0], len_lo} + HDR_EXTRA);
    put_word(START_BYTE);
    put_word(len_hi);
    put_word(len_lo);
    put_word(ptype);
    if (total > 4) put_word(ctrl);
    for (int i = 5; i < total; i++) put_word(filler());
  endfunction

  // Packet whose start is lost: send the template from offset off on
  function automatic void put_realigned(bit coded, int off);
    logic [NRES-1:0][7:0] tpl;
    int                   total;
    tpl   = coded ? TPL_CODED : TPL_AUDIO;
    total = int'({tpl[1][3:0], tpl[2]} + HDR_EXTRA);
    for (int i = off; i < off + 3; i++) put_word(tpl[i]);
    for (int i = off + 3; i < total; i++) put_word(filler());
  endfunction

  // Template triple with one bit flipped: must be dropped
  function automatic void put_near_miss();
    logic [NRES-1:0][7:0] tpl;
    logic [7:0]           b;
    int                   off, pos;
    tpl = $urandom_range(0, 1) ? TPL_CODED : TPL_AUDIO;
    off = $urandom_range(1, 3);
    pos = $urandom_range(0, 2);
    for (int i = 0; i < 3; i++) begin
      b = tpl[off+i];
      if (i == pos) b = b ^ (8'h01 << $urandom_range(0, 7));
      put_word(b);
    end
  endfunction

  // Driver: present words from rx_q, random gap after each, honor pause marks
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      in_rx_byte <= 8'h00;
      snd_wait   <= 0;
      dp_phase   = PH_IDLE;
      dp_held[0] = '0;
      dp_held[1] = '0;
      dp_type    = '0;
      dp_ctrl    = '0;
      dp_len     = '0;
      dp_cnt     = '0;
      dp_realign = 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        deframe_word(in_rx_byte);
        n_words_in++;
      end
      if (!in_valid || in_ready) begin
        if (snd_wait > 0) begin
          snd_wait <= snd_wait - 1;
          in_valid <= 1'b0;
        end else if (rx_q.size() != 0 && !(rx_q[0].hold && deframed_q.size() != 0)) begin
          in_rx_byte <= rx_q[0].b;
          in_valid   <= 1'b1;
          void'(rx_q.pop_front());
          if ($urandom_range(0, 39) == 0) snd_fast = !snd_fast;
          snd_wait <= snd_fast ? 0 : $urandom_range(0, MAX_WAIT);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result word against the oldest owed one, then stall at random
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rcv_wait  <= 0;
    end else if (out_valid && out_ready) begin
      if (deframed_q.size() == 0) begin
        $error("unexpected result word: byte %0h, index %0d", out_byte, out_byte_index);
        n_errors++;
      end else begin
        check_field("out_byte", 13'(deframed_q[0].data), 13'(out_byte));
        check_field("out_byte_index", deframed_q[0].idx, out_byte_index);
        check_field("out_byte_valid", 13'(deframed_q[0].vld), 13'(out_byte_valid));
        check_field("out_packet_end", 13'(deframed_q[0].last), 13'(out_packet_end));
        check_field("out_packet_kind", 13'(deframed_q[0].kind), 13'(out_packet_kind));
        check_field("out_realigned", 13'(deframed_q[0].realign), 13'(out_realigned));
        n_results++;
        if (!deframed_q[0].vld) n_drops++;
        else if (deframed_q[0].last) begin
          kind_seen[deframed_q[0].kind]++;
          if (deframed_q[0].realign) n_realigned++;
        end
        void'(deframed_q.pop_front());
      end
      if ($urandom_range(0, 39) == 0) rcv_fast = !rcv_fast;
      rcv_draw = rcv_fast ? 0 : $urandom_range(0, MAX_WAIT);
      out_ready <= (rcv_draw == 0);
      rcv_wait  <= rcv_draw;
    end else if (rcv_wait > 0) begin
      rcv_wait  <= rcv_wait - 1;
      out_ready <= (rcv_wait == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Build stimulus, reset, then wait for the block to drain
  initial begin
    int         pick;
    logic [7:0] hi, ptype, ctrl;

    // Directed: every kind, short packets, drops and realignments
    put_packet(8'h00, 8'h01, TYPE_CTRL, CTRL_PRODUCT);
    put_packet(8'h00, 8'h01, TYPE_CTRL, CTRL_RATE);
    put_packet(8'h00, 8'h01, TYPE_CTRL, CTRL_READY);
    put_packet(8'hF0, 8'h00, TYPE_CTRL, 8'h00);
    put_packet(8'h00, 8'h00, TYPE_AUDIO, 8'h00);
    put_packet(8'h00, 8'h02, TYPE_CODED, START_BYTE);
    put_packet(8'h00, 8'h01, 8'hFF, 8'hFF);
    put_word(8'hFF);
    put_word(8'h00);
    put_word(8'h42);
    put_word(8'h01);
    put_word(8'h42);
    put_word(8'h03);
    for (int off = 1; off < 4; off++) put_realigned(1'b1, off);
    // Audio start lost at the widest offset: six rebuilt words, long body
    put_realigned(1'b0, 3);
    // Short audio packet, sent only once the block has drained
    pause_next = 1'b1;
    put_packet(8'h00, 8'h03, TYPE_AUDIO, filler());

    // Random: top up with well-formed packets, lost starts, near misses and noise
    while (rx_q.size() < N_WORDS) begin
      if ($urandom_range(0, 24) == 0) pause_next = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        hi = 8'($urandom);
        hi[3:0] = 4'h0;
        case ($urandom_range(0, 4))
          0:       ptype = TYPE_AUDIO;
          1:       ptype = TYPE_CODED;
          2, 3:    ptype = TYPE_CTRL;
          default: ptype = filler();
        endcase
        case ($urandom_range(0, 3))
          0:       ctrl = CTRL_PRODUCT;
          1:       ctrl = CTRL_RATE;
          2:       ctrl = CTRL_READY;
          default: ctrl = filler();
        endcase
        put_packet(hi, 8'($urandom_range(0, 20)), ptype, ctrl);
      end else if (pick < 75) begin
        put_realigned(1'b1, $urandom_range(1, 3));
      end else if (pick < 90) begin
        put_near_miss();
      end else begin
        repeat ($urandom_range(1, 5)) put_word(filler());
      end
    end

    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (rx_q.size() != 0 || in_valid) @(posedge clk);
    while (deframed_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d words; checked %0d result words, %0d drop notices, %0d realigned packets.",
             n_words_in, n_results, n_drops, n_realigned);
    $display("Packet ends: audio %0d, coded voice %0d, product id %0d, rate ack %0d, unknown %0d.",
             kind_seen[KIND_AUDIO], kind_seen[KIND_CODED], kind_seen[KIND_PRODUCT],
             kind_seen[KIND_RATE], kind_seen[KIND_UNKNOWN]);
    if (n_errors == 0 && deframed_q.size() == 0) begin
      $display("vocoder_packet_deframer_tb passed");
    end else begin
      $display("vocoder_packet_deframer_tb failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #12000000;
    $display("vocoder_packet_deframer_tb failed");
    $finish;
  end

endmodule
